### rtl/lpht_pkg.sv
// Shared types, widths and codes for the linear-probing hash table.
`default_nettype none

package lpht_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W      = 10;
    localparam int CFG_W      = 11;
    localparam int STATUS_W   = 2;
    localparam int OUT_VAL_W  = 32;
    localparam int IN_VAL_W   = 32;
    localparam int PROBE_W    = 11;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Table size after reset
    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1024;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // One request item
    typedef struct packed {
        logic                        opcode;
        logic [KEY_W-1:0]            key;
        logic signed [IN_VAL_W-1:0]  value;
    } req_t;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic [KEY_W-1:0]            slot;
        logic signed [OUT_VAL_W-1:0] found_value;
        logic [PROBE_W-1:0]          probe_count;
    } rsp_t;

    // Start command to the remainder unit
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
    } mod_cmd_t;

endpackage

`default_nettype wire

### rtl/lpht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/lpht_mod.sv
// Restoring remainder unit: key modulo table size, one key bit per cycle.
`default_nettype none

module lpht_mod #(
    parameter int SZ_W = 11
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lpht_pkg::mod_cmd_t       cmd,
    input  wire logic [SZ_W-1:0]          divisor,
    output logic                          done,
    output logic [SZ_W-1:0]               rem
);

    import lpht_pkg::*;

    localparam int CNT_W = $clog2(KEY_W);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [KEY_W-1:0]    quo_reg,   quo_next;
    logic [SZ_W-1:0]     rem_reg,   rem_next;
    logic [SZ_W:0]       trial;
    logic [SZ_W:0]       diff;

    // Shift in the next dividend bit and subtract where it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[KEY_W-1]};
        diff      = trial - {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = cmd.dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[SZ_W-1:0];
            end
            else
            begin
                rem_next = trial[SZ_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(KEY_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

### rtl/linear_probe_hash_table.sv
// Linear-probing hash table: top level with probe sequencer and slot memory.
//
// Requests arrive on req_valid/req_ready/req (opcode, key, value); results
// leave on rsp_valid/rsp_ready/rsp (status, slot, found_value, probe_count).
// cfg_valid/cfg_ready/cfg_data writes the table size; cfg_ready is always high.
// Every slot (occupied mark, key, value) is one word of a single RAM with
// registered read data. The walk reads one slot per cycle, issuing the next
// address while the current word is checked.
// The result is registered when the walk finishes; a key at or above the
// table size first passes through the bit-serial remainder unit. The next
// request is taken the cycle after a result is registered, so one operation
// completes its walk before the next request is taken.
// An insert writes its slot as it finishes; the next read is issued in the
// following cycle, so no forwarding is needed.
// Reset: a clearing pass writes every slot empty, one slot per cycle;
// req_ready stays low until it ends.
// A stalled receiver: one finished result waits in the output register while
// the next request is walked; that walk then holds on its last slot until
// the output register frees.
`default_nettype none

module linear_probe_hash_table #(
    parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire lpht_pkg::req_t                req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output lpht_pkg::rsp_t                     rsp,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lpht_pkg::CFG_W-1:0]    cfg_data
);

    import lpht_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int SZ_W   = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
    localparam int WORD_W = 1 + KEY_W + VALUE_BITS;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MOD   = 2'd2;
    localparam logic [1:0] S_PROBE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CFG_W-1:0]      tsize_reg, tsize_next;
    logic [ADDR_W-1:0]     clr_reg,   clr_next;
    logic [ADDR_W-1:0]     cur_reg,   cur_next;
    logic [ADDR_W-1:0]     home_reg,  home_next;
    logic [SZ_W-1:0]       cnt_reg,   cnt_next;
    req_t                  req_reg,   req_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg,   rsp_next;

    logic [SZ_W-1:0]       tsize_ext;
    logic [SZ_W-1:0]       size_use;
    logic [SZ_W-1:0]       cur_inc;
    logic [ADDR_W-1:0]     nxt_pos;
    logic                  key_fits;
    logic                  out_free;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;
    logic                  rd_occ;
    logic [KEY_W-1:0]      rd_key;
    logic [VALUE_BITS-1:0] rd_val;

    mod_cmd_t              mod_cmd;
    logic                  mod_done;
    logic [SZ_W-1:0]       mod_rem;

    logic                  is_search;
    logic                  hit;
    logic                  finish;

    // Slot memory
    lpht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Home slot for keys at or above the table size
    lpht_mod #(
        .SZ_W (SZ_W)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mod_cmd),
        .divisor (size_use),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    // Size in use: zero reads as one, clamp to the slot count
    always_comb
    begin
        tsize_ext = SZ_W'(tsize_reg);
        if (tsize_ext == '0)
        begin
            size_use = SZ_W'(1);
        end
        else if (tsize_ext > SZ_W'(SLOTS))
        begin
            size_use = SZ_W'(SLOTS);
        end
        else
        begin
            size_use = tsize_ext;
        end
    end

    // Next probe position, wrapping at the size in use
    assign cur_inc  = SZ_W'(cur_reg) + SZ_W'(1);
    assign nxt_pos  = (cur_inc == size_use) ? '0 : ADDR_W'(cur_inc);
    assign key_fits = SZ_W'(req.key) < size_use;
    assign out_free = !rsp_valid_reg || rsp_ready;

    // Fields of the word read back
    assign rd_occ = ram_rdata[WORD_W-1];
    assign rd_key = ram_rdata[VALUE_BITS +: KEY_W];
    assign rd_val = ram_rdata[VALUE_BITS-1:0];

    // Slot checks during the walk
    assign is_search = (req_reg.opcode == OP_SEARCH);
    assign hit       = is_search ? (rd_occ && (rd_key == req_reg.key)) : !rd_occ;
    assign finish    = hit || (is_search && !rd_occ) || (nxt_pos == home_reg);

    // Configuration write
    assign cfg_ready  = 1'b1;
    assign tsize_next = cfg_valid ? cfg_data : tsize_reg;

    assign req_ready = (state_reg == S_IDLE);

    // Probe sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        home_next      = home_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = {1'b1, req_reg.key, VALUE_BITS'($unsigned(req_reg.value))};
        ram_raddr      = cur_reg;
        mod_cmd.start    = 1'b0;
        mod_cmd.dividend = req.key;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    cnt_next = '0;
                    if (key_fits)
                    begin
                        ram_raddr  = ADDR_W'(req.key);
                        cur_next   = ADDR_W'(req.key);
                        home_next  = ADDR_W'(req.key);
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        mod_cmd.start = 1'b1;
                        state_next    = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    ram_raddr  = ADDR_W'(mod_rem);
                    cur_next   = ADDR_W'(mod_rem);
                    home_next  = ADDR_W'(mod_rem);
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (finish)
                begin
                    if (out_free)
                    begin
                        rsp_valid_next      = 1'b1;
                        rsp_next.slot        = hit ? KEY_W'(cur_reg) : '0;
                        rsp_next.probe_count = PROBE_W'(cnt_reg);
                        rsp_next.found_value = (is_search && hit) ? OUT_VAL_W'(rd_val) : '0;
                        if (is_search)
                        begin
                            rsp_next.status = hit ? ST_FOUND : ST_NOT_FOUND;
                        end
                        else
                        begin
                            rsp_next.status = hit ? ST_INSERTED : ST_FULL;
                            ram_we          = hit;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_raddr = nxt_pos;
                    cur_next  = nxt_pos;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            tsize_reg     <= TABLE_SIZE_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            tsize_reg     <= tsize_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        home_reg <= home_next;
        cnt_reg  <= cnt_next;
        req_reg  <= req_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
